[src/fsi_pkg.sv]
package fsi_pkg;

    localparam int CAP_BITS  = 16;
    localparam int INT_BITS  = 32;
    localparam int BYTE_BITS = 8;
    localparam int CFG_BITS  = 16;

    // decimal digits of the largest magnitude, 2**(bits-1)
    function automatic int dec_digits_f(input int bits);
        logic [63:0] v;
        int          n;
        v = 64'd1 << (bits - 1);
        n = 0;
        for (int k = 0; k < 20; k++) begin
            if (v != 64'd0) begin
                n++;
                v = v / 64'd10;
            end
        end
        return n;
    endfunction

    localparam int DEC_DIGITS = dec_digits_f(INT_BITS);
    localparam int BCD_BITS   = 4 * DEC_DIGITS;
    localparam int ND_BITS    = $clog2(DEC_DIGITS + 1);
    localparam int CNT_BITS   = $clog2(INT_BITS + 1);

    localparam logic [CFG_BITS-1:0] CAP_RESET = CFG_BITS'(256);

    localparam logic [BYTE_BITS-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_BITS-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_BITS-1:0] CH_I       = 8'h69;
    localparam logic [BYTE_BITS-1:0] CH_CARET   = 8'h5E;
    localparam logic [BYTE_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [3:0]           CH_DIGIT_HI = 4'h3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_CONV,
        ST_SKIP,
        ST_CHECK,
        ST_DIG
    } state_t;

    typedef struct packed {
        logic start;
        logic shift_digit;
    } conv_ctrl_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
    } conv_stat_t;

endpackage

[src/fsi_bcd_conv.sv]
module fsi_bcd_conv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fsi_pkg::conv_ctrl_t          ctrl,
    input  logic [fsi_pkg::INT_BITS-1:0] magnitude,
    output fsi_pkg::conv_stat_t          stat
);
    import fsi_pkg::*;

    logic [INT_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0] bcd_reg, bcd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [BCD_BITS-1:0] bcd_adj;

    // shift-add-3: bump every digit of 5 or more before the next doubling
    always_comb begin
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (ctrl.start) begin
            mag_next = magnitude;
            bcd_next = '0;
            cnt_next = CNT_BITS'(INT_BITS);
        end else if (cnt_reg != '0) begin
            bcd_next = {bcd_adj[BCD_BITS-2:0], mag_reg[INT_BITS-1]};
            mag_next = {mag_reg[INT_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_BITS'(1);
        end else if (ctrl.shift_digit) begin
            bcd_next = {bcd_reg[BCD_BITS-5:0], 4'h0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy      = (cnt_reg != '0);
    assign stat.top_digit = bcd_reg[BCD_BITS-1 -: 4];

endmodule

[src/format_string_int_substitution.sv]
// Channel  Dir  Handshake                Word
// s_       in   s_valid / s_ready        s_format_byte, s_arg_value
// m_       out  m_valid / m_ready        m_out_byte, m_last_in_run, m_string_end
// cfg_     in   cfg_valid / cfg_ready    cfg_buffer_capacity
//
// Plain bytes, '%', stray directives and terminators are handled in ST_IDLE; when the
// space runs out, the terminator follows from ST_TERM.
// A %i word runs bit-serial binary-to-BCD conversion (ST_CONV), then leading zeros are
// dropped (ST_SKIP), the fit is checked (ST_CHECK) and digits go out one per cycle while
// the output is not stalled; a terminator follows from ST_TERM when the space runs out.
// Reset is synchronous on aresetn low; capacity returns to 256. m_ready low with m_valid
// high holds the output register and the emitting states; s_ready drops with it.
module format_string_int_substitution (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fsi_pkg::BYTE_BITS-1:0] s_format_byte,
    input  logic signed [fsi_pkg::INT_BITS-1:0] s_arg_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fsi_pkg::BYTE_BITS-1:0] m_out_byte,
    output logic                          m_last_in_run,
    output logic                          m_string_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fsi_pkg::CFG_BITS-1:0]  cfg_buffer_capacity
);
    import fsi_pkg::*;

    state_t              state_reg, state_next;
    logic [CFG_BITS-1:0] cap_reg, cap_next;
    logic [CAP_BITS-1:0] space_reg, space_next;
    logic                pct_reg, pct_next;
    logic                await_reg, await_next;
    logic                neg_reg, neg_next;
    logic [ND_BITS-1:0]  nd_reg, nd_next;

    logic                 m_valid_reg, m_valid_next;
    logic [BYTE_BITS-1:0] out_byte_reg;
    logic                 last_reg;
    logic                 end_reg;

    logic                 can_emit;
    logic                 emit_valid;
    logic [BYTE_BITS-1:0] emit_byte;
    logic                 emit_last;

    logic                 s_accept;
    logic                 cfg_accept;
    logic                 space_low;
    logic [CAP_BITS-1:0]  need;
    logic [CAP_BITS-1:0]  budget;
    logic                 no_fit;

    conv_ctrl_t           conv_ctrl;
    conv_stat_t           conv_stat;
    logic [INT_BITS-1:0]  conv_mag;

    fsi_bcd_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (conv_ctrl),
        .magnitude (conv_mag),
        .stat      (conv_stat)
    );

    assign can_emit   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && can_emit;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign space_low  = (space_reg <= CAP_BITS'(1));
    assign conv_mag   = s_arg_value[INT_BITS-1] ? INT_BITS'(-s_arg_value)
                                                : INT_BITS'(s_arg_value);
    assign need       = CAP_BITS'(nd_reg) + CAP_BITS'(neg_reg);
    assign budget     = space_reg - CAP_BITS'(1);
    assign no_fit     = (budget < CAP_BITS'(2)) || (need > budget);

    always_comb begin
        state_next            = state_reg;
        cap_next              = cap_reg;
        space_next            = space_reg;
        pct_next              = pct_reg;
        await_next            = await_reg;
        neg_next              = neg_reg;
        nd_next               = nd_reg;
        emit_valid            = 1'b0;
        emit_byte             = CH_NUL;
        emit_last             = 1'b1;
        conv_ctrl.start       = 1'b0;
        conv_ctrl.shift_digit = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (await_reg) begin
                        if (s_format_byte == CH_NUL) begin
                            space_next = CAP_BITS'(cap_reg);
                            pct_next   = 1'b0;
                            await_next = 1'b0;
                        end
                    end else if (space_low) begin
                        emit_valid = 1'b1;
                        if (s_format_byte == CH_NUL) begin
                            space_next = CAP_BITS'(cap_reg);
                            await_next = 1'b0;
                        end else begin
                            await_next = 1'b1;
                        end
                        pct_next = 1'b0;
                    end else if (s_format_byte == CH_NUL) begin
                        emit_valid = 1'b1;
                        space_next = CAP_BITS'(cap_reg);
                        pct_next   = 1'b0;
                        await_next = 1'b0;
                    end else if (pct_reg && s_format_byte == CH_I) begin
                        pct_next        = 1'b0;
                        neg_next        = s_arg_value[INT_BITS-1];
                        nd_next         = ND_BITS'(DEC_DIGITS);
                        conv_ctrl.start = 1'b1;
                        state_next      = ST_CONV;
                    end else if (!pct_reg && s_format_byte == CH_PERCENT) begin
                        pct_next = 1'b1;
                    end else begin
                        emit_valid = 1'b1;
                        emit_byte  = pct_reg ? CH_CARET : s_format_byte;
                        pct_next   = 1'b0;
                        space_next = space_reg - CAP_BITS'(1);
                        // space drops to one: terminator follows
                        if (space_reg <= CAP_BITS'(2)) begin
                            emit_last  = 1'b0;
                            state_next = ST_TERM;
                        end
                    end
                end
                if (cfg_accept) begin
                    cap_next   = cfg_buffer_capacity;
                    space_next = CAP_BITS'(cfg_buffer_capacity);
                    pct_next   = 1'b0;
                    await_next = 1'b0;
                end
            end
            ST_TERM: begin
                if (can_emit) begin
                    emit_valid = 1'b1;
                    pct_next   = 1'b0;
                    await_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (!conv_stat.busy) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (conv_stat.top_digit == 4'h0 && nd_reg > ND_BITS'(1)) begin
                    conv_ctrl.shift_digit = 1'b1;
                    nd_next               = nd_reg - ND_BITS'(1);
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (no_fit) begin
                    if (can_emit) begin
                        emit_valid = 1'b1;
                        emit_byte  = CH_CARET;
                        emit_last  = 1'b0;
                        state_next = ST_TERM;
                    end
                end else if (neg_reg) begin
                    if (can_emit) begin
                        emit_valid = 1'b1;
                        emit_byte  = CH_MINUS;
                        emit_last  = 1'b0;
                        space_next = space_reg - need;
                        state_next = ST_DIG;
                    end
                end else begin
                    space_next = space_reg - need;
                    state_next = ST_DIG;
                end
            end
            ST_DIG: begin
                if (can_emit) begin
                    emit_valid = 1'b1;
                    emit_byte  = {CH_DIGIT_HI, conv_stat.top_digit};
                    if (nd_reg == ND_BITS'(1)) begin
                        emit_last  = !space_low;
                        state_next = space_low ? ST_TERM : ST_IDLE;
                    end else begin
                        emit_last             = 1'b0;
                        conv_ctrl.shift_digit = 1'b1;
                        nd_next               = nd_reg - ND_BITS'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            space_reg   <= CAP_BITS'(CAP_RESET);
            pct_reg     <= 1'b0;
            await_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            space_reg   <= space_next;
            pct_reg     <= pct_next;
            await_reg   <= await_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg <= neg_next;
        nd_reg  <= nd_next;
        if (emit_valid) begin
            out_byte_reg <= emit_byte;
            last_reg     <= emit_last;
            end_reg      <= (emit_byte == CH_NUL);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_in_run = last_reg;
    assign m_string_end  = end_reg;

`ifndef NO_ASSERTIONS
    a_term_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_end |-> m_last_in_run)
        else $error("terminator word not marked last");

    a_dig_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIG |-> nd_reg != '0)
        else $error("digit state with no digits left");

    a_check_space: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> space_reg >= CAP_BITS'(2))
        else $error("number check entered with space exhausted");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> !pct_reg)
        else $error("percent flag set while skipping to format end");

    a_conv_start: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_ctrl.start |=> conv_stat.busy && state_reg == ST_CONV)
        else $error("converter did not start");
`endif

endmodule

[bench/format_string_int_substitution_tb.sv]
`timescale 1ns / 1ps

module format_string_int_substitution_tb;
    import fsi_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = INT_BITS + DEC_DIGITS + 16;

    typedef struct {
        logic [BYTE_BITS-1:0] ch;
        logic                 ends_run;
        logic                 ends_string;
    } out_char_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [BYTE_BITS-1:0]       s_format_byte;
    logic signed [INT_BITS-1:0] s_arg_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [BYTE_BITS-1:0]       m_out_byte;
    logic                       m_last_in_run;
    logic                       m_string_end;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_BITS-1:0]        cfg_buffer_capacity;

    // printf state as seen from outside
    logic [CFG_BITS-1:0] capacity;
    logic [CAP_BITS-1:0] space_left;
    bit                  percent_seen;
    bit                  skip_to_nul;

    out_char_t step_chars[$];
    out_char_t pending_chars[$];

    int  mismatches   = 0;
    int  live_words   = 0;
    int  quiet_cycles = 0;
    bit  bursts_on    = 1'b1;
    bit  hold_request = 1'b0;

    format_string_int_substitution dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_format_byte       (s_format_byte),
        .s_arg_value         (s_arg_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_byte          (m_out_byte),
        .m_last_in_run       (m_last_in_run),
        .m_string_end        (m_string_end),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_buffer_capacity (cfg_buffer_capacity)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void restart_string();
        space_left   = CAP_BITS'(capacity);
        percent_seen = 1'b0;
        skip_to_nul  = 1'b0;
    endfunction

    function automatic void emit_char(logic [BYTE_BITS-1:0] ch);
        out_char_t c;
        c.ch          = ch;
        c.ends_run    = 1'b0;
        c.ends_string = (ch == CH_NUL);
        step_chars.push_back(c);
    endfunction

    function automatic void close_string();
        emit_char(CH_NUL);
        percent_seen = 1'b0;
        skip_to_nul  = 1'b1;
    endfunction

    function automatic void put_plain(logic [BYTE_BITS-1:0] ch);
        emit_char(ch);
        if (space_left > 0)
            space_left--;
        if (space_left <= 1)
            close_string();
    endfunction

    function automatic void put_decimal(logic signed [INT_BITS-1:0] arg);
        logic [INT_BITS-1:0]  mag;
        logic [CAP_BITS-1:0]  budget;
        logic [BYTE_BITS-1:0] digits[$];
        bit                   neg;
        int                   need;
        neg = arg[INT_BITS-1];
        // unsigned negate gives the right magnitude for the most negative value too
        mag = neg ? ~arg + 1'b1 : arg;
        do begin
            digits.push_front({CH_DIGIT_HI, 4'(mag % 10)});
            mag = mag / 10;
        end while (mag != 0);
        need   = digits.size() + (neg ? 1 : 0);
        budget = space_left - 1'b1;
        if (budget < 2 || need > budget) begin
            emit_char(CH_CARET);
            close_string();
            return;
        end
        if (neg)
            emit_char(CH_MINUS);
        foreach (digits[k])
            emit_char(digits[k]);
        space_left = space_left - CAP_BITS'(need);
        if (space_left <= 1)
            close_string();
    endfunction

    // expected output chars for one accepted format word
    function automatic void format_word(logic [BYTE_BITS-1:0] b,
                                       logic signed [INT_BITS-1:0] arg);
        step_chars.delete();
        if (skip_to_nul) begin
            if (b == CH_NUL)
                restart_string();
            return;
        end
        if (space_left <= 1) begin
            emit_char(CH_NUL);
            if (b == CH_NUL) begin
                restart_string();
            end else begin
                percent_seen = 1'b0;
                skip_to_nul  = 1'b1;
            end
        end else if (b == CH_NUL) begin
            emit_char(CH_NUL);
            restart_string();
        end else if (percent_seen) begin
            percent_seen = 1'b0;
            if (b == CH_I)
                put_decimal(arg);
            else
                put_plain(CH_CARET);
        end else if (b == CH_PERCENT) begin
            percent_seen = 1'b1;
        end else begin
            put_plain(b);
        end
        if (step_chars.size() > 0)
            step_chars[step_chars.size() - 1].ends_run = 1'b1;
        foreach (step_chars[k])
            pending_chars.push_back(step_chars[k]);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatches < 20)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        out_char_t want;
        if (!aresetn) begin
            capacity = CAP_RESET;
            restart_string();
            pending_chars.delete();
            quiet_cycles = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_buffer_capacity;
                restart_string();
            end
            if (s_valid && s_ready) begin
                live_words++;
                format_word(s_format_byte, s_arg_value);
            end
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch("unexpected word, out_byte", m_out_byte, 0);
                end else begin
                    want = pending_chars.pop_front();
                    if (m_out_byte !== want.ch)
                        report_mismatch("out_byte", m_out_byte, want.ch);
                    if (m_last_in_run !== want.ends_run)
                        report_mismatch("last_in_run", m_last_in_run, want.ends_run);
                    if (m_string_end !== want.ends_string)
                        report_mismatch("string_end", m_string_end, want.ends_string);
                end
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // result sink: random short stalls, or one long hold on request
    initial begin : sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic signed [INT_BITS-1:0] rand_arg();
        case ($urandom_range(0, 5))
            1: return $urandom_range(0, 99);
            2: return -$signed(INT_BITS'($urandom_range(1, 9999)));
            3: return {1'b1, {(INT_BITS - 1){1'b0}}};
            4: return $urandom_range(0, 1) ? {1'b0, {(INT_BITS - 1){1'b1}}} : -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_capacity();
        case ($urandom_range(0, 7))
            0: return CFG_BITS'(1);
            1: return CFG_BITS'($urandom_range(0, 3));
            2: return {CFG_BITS{1'b1}};
            3: return CFG_BITS'($urandom_range(0, 65535));
            default: return CFG_BITS'($urandom_range(4, 40));
        endcase
    endfunction

    task automatic send_word(logic [BYTE_BITS-1:0] b, logic signed [INT_BITS-1:0] arg);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_format_byte <= b;
        s_arg_value   <= arg;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_int(logic signed [INT_BITS-1:0] arg);
        send_word(CH_PERCENT, rand_arg());
        send_word(CH_I, arg);
    endtask

    task automatic send_text(string txt);
        for (int k = 0; k < txt.len(); k++)
            send_word(txt[k], rand_arg());
    endtask

    task automatic send_random_string();
        logic [BYTE_BITS-1:0] b;
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 9))
                4, 5, 6: send_int(rand_arg());
                7: begin
                    send_word(CH_PERCENT, rand_arg());
                    send_word(BYTE_BITS'($urandom_range(0, 255)), rand_arg());
                end
                8: send_word(BYTE_BITS'($urandom_range(0, 255)), rand_arg());
                default: begin
                    b = BYTE_BITS'($urandom_range(1, 255));
                    if (b == CH_PERCENT)
                        b = "a";
                    send_word(b, rand_arg());
                end
            endcase
        end
        send_word(CH_NUL, rand_arg());
    endtask

    // wait until every expected word is out and the block has settled
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CFG_BITS-1:0] cap);
        drain_block();
        cfg_valid           <= 1'b1;
        cfg_buffer_capacity <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_word(8'hFF, rand_arg());
        send_word(8'h01, rand_arg());
        send_int({1'b1, {(INT_BITS - 1){1'b0}}});
        send_int({1'b0, {(INT_BITS - 1){1'b1}}});
        send_int(0);
        send_text("%%%x");
        // percent directly followed by the terminator
        send_word(CH_PERCENT, rand_arg());
        send_word(CH_NUL, rand_arg());
    endtask

    task automatic test_capacity_extremes();
        write_capacity(CFG_BITS'(1));
        send_word("a", rand_arg());
        send_word(CH_NUL, rand_arg());
        write_capacity(CFG_BITS'(0));
        send_word(CH_NUL, rand_arg());
        // no room for any digit: caret then terminator
        write_capacity(CFG_BITS'(2));
        send_int(5);
        send_word(CH_NUL, rand_arg());
        // exact fit uses up the space
        write_capacity(CFG_BITS'(4));
        send_int(-12);
        send_word(CH_NUL, rand_arg());
    endtask

    task automatic test_output_stall();
        write_capacity({CFG_BITS{1'b1}});
        hold_request = 1'b1;
        repeat (12) begin
            send_int(rand_arg());
            send_word("x", rand_arg());
        end
        send_word(CH_NUL, rand_arg());
    endtask

    task automatic test_random_strings();
        int target;
        target = live_words + 150;
        while (live_words < target) begin
            write_capacity(rand_capacity());
            repeat ($urandom_range(1, 4)) send_random_string();
        end
    endtask

    task automatic test_steady_stream();
        bursts_on = 1'b0;
        write_capacity(CAP_RESET);
        repeat (4) send_random_string();
    endtask

    initial begin
        aresetn             <= 1'b0;
        s_valid             <= 1'b0;
        s_format_byte       <= '0;
        s_arg_value         <= '0;
        cfg_valid           <= 1'b0;
        cfg_buffer_capacity <= CAP_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_capacity_extremes();
        test_output_stall();
        test_random_strings();
        test_steady_stream();
        drain_block();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
